/* rtl/udprw_pkg.sv */
`default_nettype none
package udprw_pkg;

	// table sizes
	localparam int MAX_SERVERS      = 8;
	localparam int REDIRECT_ENTRIES = 256;
	localparam int SRV_DEPTH        = MAX_SERVERS + 1;
	localparam int SRV_AW           = (SRV_DEPTH > 1) ? $clog2(SRV_DEPTH) : 1;
	localparam int RDR_AW           = $clog2(REDIRECT_ENTRIES);

	// stream widths
	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 88;
	localparam int M_TUSER_W = 2;

	// command codes
	localparam logic [1:0] CMD_FRAME    = 2'd0;
	localparam logic [1:0] CMD_REDIRECT = 2'd1;
	localparam logic [1:0] CMD_SERVER   = 2'd2;

	// verdict codes
	localparam logic [1:0] VERDICT_PASS    = 2'd0;
	localparam logic [1:0] VERDICT_ABORT   = 2'd1;
	localparam logic [1:0] VERDICT_REWRITE = 2'd2;

	// frame offsets
	localparam logic [5:0] POS_ETH_HI   = 6'd12;
	localparam logic [5:0] POS_ETH_LO   = 6'd13;
	localparam logic [5:0] POS_IP_FIRST = 6'd14;
	localparam logic [5:0] POS_PROTO    = 6'd23;
	localparam logic [5:0] POS_IP_LAST  = 6'd23;
	localparam logic [5:0] POS_PORT_HI  = 6'd36;
	localparam logic [5:0] POS_PORT_LO  = 6'd37;
	localparam logic [5:0] POS_KEY      = 6'd42;
	localparam logic [5:0] POS_MAX      = 6'd63;

	// header match values
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
	localparam logic [15:0] UDP_PORT       = 16'd7777;

endpackage
`default_nettype wire

/* rtl/udprw_ram.sv */
`default_nettype none
module udprw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read port with read-old-data behavior
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/udp_redirect_header_rewriter.sv */
`default_nettype none
// UDP redirect header rewriter. Takes one item per clock: frame bytes (tuser command 0) of an
// untagged Ethernet/IPv4 frame with a 20-byte header, redirect table writes (command 1) and
// server address writes (command 2), all on the same input stream. The last byte of a frame
// (tlast) yields one result item: pass, abort or rewrite with new source/destination addresses
// and a recomputed IPv4 header checksum. Throughput is one input item per cycle unless the
// input is held off; a result reaches the output through four register stages: the redirect
// table read, the dependent server table read, the checksum sum and the carry fold. The input
// is held off only while all four stages hold results and the output is not ready.
// Redirect entries are invalid after reset; server entries must be written before use.
module udp_redirect_header_rewriter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// data_byte[7:0], table_index[15:8], entry_valid[16], entry_server[24:17],
	// server_address[56:25], zero fill
	input  wire logic [udprw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	input  wire logic                              s_axis_tlast,
	// command[1:0]
	input  wire logic [udprw_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// chosen_server[7:0], new_source[39:8], new_destination[71:40], new_checksum[87:72]
	output logic      [udprw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// verdict[1:0]
	output logic      [udprw_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

	import udprw_pkg::*;

	// input field split
	logic [1:0]  cmd;
	logic [7:0]  in_byte;
	logic [7:0]  in_idx;
	logic        in_ev;
	logic [7:0]  in_es;
	logic [31:0] in_addr;

	assign cmd     = s_axis_tuser;
	assign in_byte = s_axis_tdata[7:0];
	assign in_idx  = s_axis_tdata[15:8];
	assign in_ev   = s_axis_tdata[16];
	assign in_es   = s_axis_tdata[24:17];
	assign in_addr = s_axis_tdata[56:25];

	// frame state
	logic [5:0]  pos_q;
	logic [19:0] sum_q;
	logic [2:0]  flags_q;
	logic [7:0]  key_q;
	logic [REDIRECT_ENTRIES-1:0] rvld_q;
	logic [31:0] src_q;

	// pipeline control
	logic v1_s1, v2_s2, v3_s3, out_valid_q;
	logic adv1, adv2, adv3, adv_o;
	logic fire, frame_fire, last_fire;

	assign adv_o = !out_valid_q || m_axis_tready;
	assign adv3  = !v3_s3 || adv_o;
	assign adv2  = !v2_s2 || adv3;
	assign adv1  = !v1_s1 || adv2;
	assign s_axis_tready = adv1;

	assign fire       = s_axis_tvalid && s_axis_tready;
	assign frame_fire = fire && (cmd == CMD_FRAME);
	assign last_fire  = frame_fire && s_axis_tlast;

	// header checks and word sum for the current byte
	logic [2:0]  flags_nx;
	logic [19:0] sum_nx;
	logic [7:0]  key_nx;
	logic [5:0]  pos_nx;
	logic        elig;

	always_comb begin
		flags_nx = flags_q;
		case (pos_q)
			POS_ETH_HI:  if (in_byte != ETHERTYPE_IPV4[15:8]) flags_nx[0] = 1'b1;
			POS_ETH_LO:  if (in_byte != ETHERTYPE_IPV4[7:0]) flags_nx[0] = 1'b1;
			POS_PROTO:   if (in_byte != IP_PROTO_UDP) flags_nx[1] = 1'b1;
			POS_PORT_HI: if (in_byte != UDP_PORT[15:8]) flags_nx[2] = 1'b1;
			POS_PORT_LO: if (in_byte != UDP_PORT[7:0]) flags_nx[2] = 1'b1;
			default: ;
		endcase
		sum_nx = sum_q;
		if (pos_q >= POS_IP_FIRST && pos_q <= POS_IP_LAST) begin
			sum_nx = sum_q + (pos_q[0] ? {12'd0, in_byte} : {4'd0, in_byte, 8'd0});
		end
		key_nx = (pos_q == POS_KEY) ? in_byte : key_q;
		pos_nx = (pos_q < POS_MAX) ? pos_q + 6'd1 : pos_q;
		elig   = (flags_nx == 3'd0) && (pos_q >= POS_KEY);
	end

	// frame state update, cleared after each verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			flags_q <= '0;
			key_q   <= '0;
		end else if (frame_fire) begin
			if (s_axis_tlast) begin
				pos_q   <= '0;
				sum_q   <= '0;
				flags_q <= '0;
				key_q   <= '0;
			end else begin
				pos_q   <= pos_nx;
				sum_q   <= sum_nx;
				flags_q <= flags_nx;
				key_q   <= key_nx;
			end
		end
	end

	// redirect entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q <= '0;
		end else if (fire && cmd == CMD_REDIRECT) begin
			rvld_q[in_idx[RDR_AW-1:0]] <= in_ev;
		end
	end

	// server entry 0 copy for the source address
	always_ff @(posedge clk) begin
		if (fire && cmd == CMD_SERVER && in_idx == 8'd0) begin
			src_q <= in_addr;
		end
	end

	// redirect table: server index per key
	logic [7:0] rsrv;

	udprw_ram #(
		.WIDTH(8),
		.DEPTH(REDIRECT_ENTRIES)
	) u_rdr_ram (
		.clk   (clk),
		.we    (fire && cmd == CMD_REDIRECT),
		.waddr (in_idx[RDR_AW-1:0]),
		.wdata (in_es),
		.re    (last_fire),
		.raddr (key_nx[RDR_AW-1:0]),
		.rdata (rsrv)
	);

	// stage 1: redirect entry available
	logic        elig_s1, vld_s1;
	logic [19:0] sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (adv1) begin
			v1_s1 <= last_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (last_fire) begin
			elig_s1 <= elig;
			vld_s1  <= rvld_q[key_nx[RDR_AW-1:0]];
			sum_s1  <= sum_nx;
		end
	end

	logic       big1;
	logic [1:0] verd1;
	logic [7:0] srv1;

	always_comb begin
		big1 = rsrv > 8'(MAX_SERVERS);
		if (!elig_s1) begin
			verd1 = VERDICT_PASS;
		end else if (!vld_s1 || big1) begin
			verd1 = VERDICT_ABORT;
		end else begin
			verd1 = VERDICT_REWRITE;
		end
		srv1 = (elig_s1 && vld_s1) ? rsrv : 8'd0;
	end

	// server table, written only for indexes in range
	logic [31:0] srd;
	logic        srv_re;

	assign srv_re = v1_s1 && adv2;

	udprw_ram #(
		.WIDTH(32),
		.DEPTH(SRV_DEPTH)
	) u_srv_ram (
		.clk   (clk),
		.we    (fire && cmd == CMD_SERVER && in_idx <= 8'(MAX_SERVERS)),
		.waddr (in_idx[SRV_AW-1:0]),
		.wdata (in_addr),
		.re    (srv_re),
		.raddr (big1 ? '0 : rsrv[SRV_AW-1:0]),
		.rdata (srd)
	);

	// stage 2: server address available, one's complement sum
	logic [1:0]  verd_s2;
	logic [7:0]  srv_s2;
	logic [19:0] sum_s2;
	logic [31:0] src_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (adv2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (srv_re) begin
			verd_s2 <= verd1;
			srv_s2  <= srv1;
			sum_s2  <= sum_s1;
			src_s2  <= src_q;
		end
	end

	logic        rw2;
	logic [31:0] src2, dst2;
	logic [20:0] tot2;

	always_comb begin
		rw2  = verd_s2 == VERDICT_REWRITE;
		src2 = rw2 ? src_s2 : 32'd0;
		dst2 = rw2 ? srd : 32'd0;
		tot2 = {1'b0, sum_s2} + {5'd0, src2[31:16]} + {5'd0, src2[15:0]}
			+ {5'd0, dst2[31:16]} + {5'd0, dst2[15:0]};
	end

	// stage 3: fold carries and invert
	logic [1:0]  verd_s3;
	logic [7:0]  srv_s3;
	logic [31:0] src_s3, dst_s3;
	logic [20:0] tot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (adv3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v2_s2 && adv3) begin
			verd_s3 <= verd_s2;
			srv_s3  <= srv_s2;
			src_s3  <= src2;
			dst_s3  <= dst2;
			tot_s3  <= tot2;
		end
	end

	logic [16:0] fold_a;
	logic [15:0] fold_b;
	logic [15:0] csum3;

	always_comb begin
		fold_a = {1'b0, tot_s3[15:0]} + {12'd0, tot_s3[20:16]};
		fold_b = fold_a[15:0] + {15'd0, fold_a[16]};
		csum3  = (verd_s3 == VERDICT_REWRITE) ? ~fold_b : 16'd0;
	end

	// output register
	logic [1:0]           m_verd_q;
	logic [M_TDATA_W-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_o) begin
			out_valid_q <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v3_s3 && adv_o) begin
			m_verd_q <= verd_s3;
			m_data_q <= {csum3, dst_s3, src_s3, srv_s3};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = m_verd_q;
	assign m_axis_tdata  = m_data_q;

`ifndef ASSERT_OFF
	// a rewrite always names a server inside the table
	a_rewrite_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == VERDICT_REWRITE) |->
		(m_axis_tdata[7:0] <= 8'(MAX_SERVERS)))
		else $error("rewrite with server index out of range");

	// a pass result carries no server, addresses or checksum
	a_pass_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == VERDICT_PASS) |-> (m_axis_tdata == '0))
		else $error("pass result with nonzero fields");

	// an empty first stage never holds off the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_s1 |-> s_axis_tready)
		else $error("input stalled with empty pipeline");

	// a verdict enters the pipeline only from a last frame byte
	a_stage_source: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && !last_fire) |=> !v1_s1)
		else $error("stage one loaded without a last frame byte");
`endif

endmodule
`default_nettype wire
